### hdl/program_stream_video_demux_assert.svh
// Assertion macros used by the demux parser.
`ifndef PROGRAM_STREAM_VIDEO_DEMUX_ASSERT_SVH
`define PROGRAM_STREAM_VIDEO_DEMUX_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PSVD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psvd assertion failed");

// Next-cycle implication, checked out of reset.
`define PSVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psvd assertion failed");

`endif

### hdl/psvd_pkg.sv
// Shared types and constants for the program stream video demux.
`timescale 1ns / 1ps
package psvd_pkg;

  typedef enum logic [2:0] {
    ST_PAYLOAD     = 3'd0,
    ST_PROGRAM_END = 3'd1,
    ST_BAD_PACK    = 3'd2,
    ST_NOT_SYSTEM  = 3'd3,
    ST_DROPPED     = 3'd4,
    ST_SYNC_LOST   = 3'd5
  } status_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
    status_t    status;
  } result_t;

  localparam logic [23:0] START_PREFIX = 24'h000001;
  localparam logic [23:0] WINDOW_IDLE  = 24'hffffff;
  localparam logic [7:0]  CODE_END     = 8'hb9;
  localparam logic [7:0]  CODE_PACK    = 8'hba;
  localparam logic [7:0]  STUFF_BYTE   = 8'hff;
  localparam logic [7:0]  VIDEO_ID_RST = 8'he0;

endpackage

### hdl/psvd_in_stage.sv
// Input register stage: holds one raw stream byte until the parser takes it.
`timescale 1ns / 1ps
module psvd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       can_load,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || can_load;
  assign s1_valid = valid_r;
  assign s1_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
    end
  end

endmodule

### hdl/psvd_parser.sv
// Stream parser: start code hunt, header skipping and payload extraction per byte.
`timescale 1ns / 1ps
`include "program_stream_video_demux_assert.svh"
module psvd_parser #(
  parameter int MAX_STUFFING = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  logic              step,
  input  logic [7:0]        b,
  output psvd_pkg::result_t res
);

  localparam int STUFF_W = $clog2(MAX_STUFFING + 1);

  typedef enum logic [3:0] {
    PH_HUNT, PH_PACK_KIND, PH_PACK2, PH_SKIP_FIX,
    PH_VLEN_HI, PH_VLEN_LO, PH_OLEN_HI, PH_OLEN_LO,
    PH_SKIP_PKT, PH_M2_FLAGS, PH_M2_HLEN, PH_VID_SKIP,
    PH_M1_STUFF, PH_M1_STD2, PH_M1_TS, PH_PAYLOAD
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic [23:0]          win_r, win_nxt;
  logic [15:0]          pbl_r, pbl_nxt;
  logic [7:0]           hbl_r, hbl_nxt;
  logic [STUFF_W-1:0]   stuff_r, stuff_nxt;
  logic [7:0]           lenhi_r, lenhi_nxt;
  logic                 reported_r, reported_nxt;
  logic                 stopped_r, stopped_nxt;
  logic [7:0]           vid_r;

  logic [15:0]          pbl_dec;
  logic                 last;
  logic [7:0]           hbl_dec;
  logic [7:0]           hbl_inc;
  logic [23:0]          win_shift;
  logic                 ts_ok;
  logic [7:0]           ts_hbl;
  phase_t               ts_phase;
  logic                 sync_item;
  logic                 status_item;

  assign pbl_dec   = (pbl_r != 16'd0) ? pbl_r - 16'd1 : pbl_r;
  assign last      = (pbl_dec == 16'd0);
  assign hbl_dec   = (hbl_r != 8'd0) ? hbl_r - 8'd1 : hbl_r;
  assign hbl_inc   = hbl_r + 8'd1;
  assign win_shift = {win_r[15:0], b};

  assign sync_item   = res.valid && res.status == psvd_pkg::ST_SYNC_LOST;
  assign status_item = res.valid && res.status != psvd_pkg::ST_PAYLOAD;

  // MPEG-1 timestamp marker forms
  always_comb begin
    ts_ok    = 1'b1;
    ts_hbl   = 8'd0;
    ts_phase = PH_PAYLOAD;
    unique case (b[7:4])
      4'h0: begin
        ts_hbl   = 8'd0;
        ts_phase = PH_PAYLOAD;
      end
      4'h2: begin
        ts_hbl   = 8'd4;
        ts_phase = PH_VID_SKIP;
      end
      4'h3: begin
        ts_hbl   = 8'd9;
        ts_phase = PH_VID_SKIP;
      end
      default: ts_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt    = phase_r;
    win_nxt      = win_r;
    pbl_nxt      = pbl_r;
    hbl_nxt      = hbl_r;
    stuff_nxt    = stuff_r;
    lenhi_nxt    = lenhi_r;
    reported_nxt = reported_r;
    stopped_nxt  = stopped_r;
    res          = '0;
    res.status   = psvd_pkg::ST_PAYLOAD;
    if (!stopped_r) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (win_r == psvd_pkg::START_PREFIX) begin
            priority if (b == psvd_pkg::CODE_END) begin
              stopped_nxt = 1'b1;
              res.valid   = 1'b1;
              res.status  = psvd_pkg::ST_PROGRAM_END;
            end else if (b == psvd_pkg::CODE_PACK) begin
              phase_nxt = PH_PACK_KIND;
            end else if (b == vid_r) begin
              phase_nxt = PH_VLEN_HI;
            end else if (b < psvd_pkg::CODE_END) begin
              stopped_nxt = 1'b1;
              res.valid   = 1'b1;
              res.status  = psvd_pkg::ST_NOT_SYSTEM;
            end else begin
              phase_nxt = PH_OLEN_HI;
            end
          end else begin
            win_nxt = win_shift;
            if (hbl_r < 8'd3) begin
              hbl_nxt = hbl_inc;
              if (hbl_inc == 8'd3 && win_shift != psvd_pkg::START_PREFIX &&
                  !reported_r) begin
                reported_nxt = 1'b1;
                res.valid    = 1'b1;
                res.status   = psvd_pkg::ST_SYNC_LOST;
              end
            end
          end
        end
        PH_PACK_KIND: begin
          priority if (b[7:6] == 2'b01) begin
            hbl_nxt   = 8'd9;
            phase_nxt = PH_PACK2;
          end else if (b[7:4] == 4'b0010) begin
            hbl_nxt   = 8'd7;
            phase_nxt = PH_SKIP_FIX;
          end else begin
            stopped_nxt = 1'b1;
            res.valid   = 1'b1;
            res.status  = psvd_pkg::ST_BAD_PACK;
          end
        end
        PH_PACK2: begin
          hbl_nxt = hbl_dec;
          if (hbl_dec == 8'd0) begin
            if (b[2:0] != 3'd0) begin
              hbl_nxt   = {5'd0, b[2:0]};
              phase_nxt = PH_SKIP_FIX;
            end else begin
              phase_nxt = PH_HUNT;
              win_nxt   = psvd_pkg::WINDOW_IDLE;
              hbl_nxt   = 8'd0;
            end
          end
        end
        PH_SKIP_FIX: begin
          hbl_nxt = hbl_dec;
          if (hbl_dec == 8'd0) begin
            phase_nxt = PH_HUNT;
            win_nxt   = psvd_pkg::WINDOW_IDLE;
          end
        end
        PH_VLEN_HI: begin
          lenhi_nxt = b;
          phase_nxt = PH_VLEN_LO;
        end
        PH_OLEN_HI: begin
          lenhi_nxt = b;
          phase_nxt = PH_OLEN_LO;
        end
        PH_VLEN_LO, PH_OLEN_LO: begin
          pbl_nxt = {lenhi_r, b};
          priority if ({lenhi_r, b} == 16'd0) begin
            phase_nxt = PH_HUNT;
            win_nxt   = psvd_pkg::WINDOW_IDLE;
            hbl_nxt   = 8'd0;
          end else if (phase_r == PH_VLEN_LO) begin
            stuff_nxt = '0;
            phase_nxt = PH_M1_STUFF;
          end else begin
            phase_nxt = PH_SKIP_PKT;
          end
        end
        default: begin
          // packet body
          pbl_nxt = pbl_dec;
          unique case (phase_r)
            PH_M2_FLAGS: phase_nxt = PH_M2_HLEN;
            PH_M2_HLEN: begin
              hbl_nxt   = b;
              phase_nxt = (b == 8'd0) ? PH_PAYLOAD : PH_VID_SKIP;
            end
            PH_VID_SKIP: begin
              hbl_nxt = hbl_dec;
              if (hbl_dec == 8'd0) begin
                phase_nxt = PH_PAYLOAD;
              end
            end
            PH_M1_STUFF: begin
              priority if (stuff_r == '0 && b[7:6] == 2'b10) begin
                phase_nxt = PH_M2_FLAGS;
              end else if (b == psvd_pkg::STUFF_BYTE) begin
                if (stuff_r >= STUFF_W'(MAX_STUFFING)) begin
                  phase_nxt  = PH_SKIP_PKT;
                  res.valid  = 1'b1;
                  res.status = psvd_pkg::ST_DROPPED;
                end else begin
                  stuff_nxt = stuff_r + STUFF_W'(1);
                end
              end else if (b[7:6] == 2'b01) begin
                phase_nxt = PH_M1_STD2;
              end else if (ts_ok) begin
                hbl_nxt   = ts_hbl;
                phase_nxt = ts_phase;
              end else begin
                phase_nxt  = PH_SKIP_PKT;
                res.valid  = 1'b1;
                res.status = psvd_pkg::ST_DROPPED;
              end
            end
            PH_M1_STD2: phase_nxt = PH_M1_TS;
            PH_M1_TS: begin
              if (ts_ok) begin
                hbl_nxt   = ts_hbl;
                phase_nxt = ts_phase;
              end else begin
                phase_nxt  = PH_SKIP_PKT;
                res.valid  = 1'b1;
                res.status = psvd_pkg::ST_DROPPED;
              end
            end
            PH_PAYLOAD: begin
              res.valid = 1'b1;
              res.data  = b;
              res.last  = last;
            end
            default: ;
          endcase
          if (last) begin
            phase_nxt = PH_HUNT;
            win_nxt   = psvd_pkg::WINDOW_IDLE;
            hbl_nxt   = 8'd0;
          end
        end
      endcase
    end
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      win_r      <= psvd_pkg::WINDOW_IDLE;
      pbl_r      <= 16'd0;
      hbl_r      <= 8'd0;
      stuff_r    <= '0;
      lenhi_r    <= 8'd0;
      reported_r <= 1'b0;
      stopped_r  <= 1'b0;
      vid_r      <= psvd_pkg::VIDEO_ID_RST;
    end else begin
      if (step) begin
        phase_r    <= phase_nxt;
        win_r      <= win_nxt;
        pbl_r      <= pbl_nxt;
        hbl_r      <= hbl_nxt;
        stuff_r    <= stuff_nxt;
        lenhi_r    <= lenhi_nxt;
        reported_r <= reported_nxt;
        stopped_r  <= stopped_nxt;
      end
      if (cfg_we) begin
        vid_r <= cfg_data;
      end
    end
  end

  `PSVD_ASSERT_NOW(a_halt_silent, clk, rst_n, stopped_r, !res.valid)
  `PSVD_ASSERT_NEXT(a_halt_sticky, clk, rst_n, stopped_r, stopped_r)
  `PSVD_ASSERT_NEXT(a_sync_once, clk, rst_n, reported_r, reported_r && !sync_item)
  `PSVD_ASSERT_NOW(a_status_clean, clk, rst_n, status_item, res.data == 8'd0 && !res.last)

endmodule

### hdl/psvd_out_stage.sv
// Result register: holds one result item until the receiver takes it.
`timescale 1ns / 1ps
module psvd_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  psvd_pkg::result_t res,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_of_packet,
  output logic [2:0]        out_status
);

  logic              valid_r;
  psvd_pkg::result_t data_r;

  assign can_load           = !valid_r || out_ready;
  assign out_valid          = valid_r;
  assign out_byte           = data_r.data;
  assign out_last_of_packet = data_r.last;
  assign out_status         = data_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= res.valid;
    end
    if (can_load && res.valid) begin
      data_r <= res;
    end
  end

endmodule

### hdl/program_stream_video_demux.sv
// MPEG program stream video demux: one raw byte in, at most one result item out.
// Usage:
//   Input channel in_valid/in_ready/in_byte carries the raw stream, one byte per item.
//   Result channel out_valid/out_ready carries out_byte, out_last_of_packet and
//   out_status (0 payload, 1 program end, 2 bad pack header, 3 not system stream,
//   4 packet dropped, 5 sync lost). Header and skipped bytes produce no item.
//   cfg_we/cfg_data set the video stream id (0xE0 after reset); write only when idle.
// Timing: a byte is loaded into the input register at acceptance; its result is loaded
//   into the result register when the parser steps on it. Throughput: one byte per
//   cycle unless stalled, set by the parser step between the two registers.
// Reset: synchronous, active low; parser goes to start code hunt, both registers
//   empty. After program end or a halting error no more results until reset.
// Stall: while the result register is full and out_ready is low, the parser holds
//   its byte and in_ready drops once the input register is also full.
`timescale 1ns / 1ps
module program_stream_video_demux #(
  parameter int MAX_STUFFING = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_packet,
  output logic [2:0] out_status,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  logic              can_load;
  logic              s1_valid;
  logic [7:0]        s1_byte;
  psvd_pkg::result_t res;

  psvd_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .can_load (can_load),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  psvd_parser #(
    .MAX_STUFFING (MAX_STUFFING)
  ) u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .step     (s1_valid && can_load),
    .b        (s1_byte),
    .res      (res)
  );

  psvd_out_stage u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .res                (res),
    .can_load           (can_load),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_packet (out_last_of_packet),
    .out_status         (out_status)
  );

endmodule
